// ----- hdl/aligned_residue_pair_statistics_macros.svh -----
// assertion macros for the aligned residue pair statistics block
// used by the top level; needs nothing else
`ifndef ALIGNED_RESIDUE_PAIR_STATISTICS_MACROS_SVH
`define ALIGNED_RESIDUE_PAIR_STATISTICS_MACROS_SVH

// antecedent holds in this cycle, consequent in the same cycle
`define ARPS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds in this cycle, consequent in the next one
`define ARPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/arps_pkg.sv -----
// shared types, residue codes and the substitution table
// for the aligned residue pair statistics block; no dependencies
`default_nettype none

package arps_pkg;

    localparam logic [7:0] CH_GAP = 8'h2E;
    localparam logic [7:0] CH_UNK = 8'h58;
    localparam logic [7:0] CH_A   = 8'h41;
    localparam logic [7:0] CH_D   = 8'h44;
    localparam logic [7:0] CH_E   = 8'h45;
    localparam logic [7:0] CH_F   = 8'h46;
    localparam logic [7:0] CH_I   = 8'h49;
    localparam logic [7:0] CH_K   = 8'h4B;
    localparam logic [7:0] CH_L   = 8'h4C;
    localparam logic [7:0] CH_N   = 8'h4E;
    localparam logic [7:0] CH_Q   = 8'h51;
    localparam logic [7:0] CH_R   = 8'h52;
    localparam logic [7:0] CH_S   = 8'h53;
    localparam logic [7:0] CH_T   = 8'h54;
    localparam logic [7:0] CH_V   = 8'h56;
    localparam logic [7:0] CH_Y   = 8'h59;

    // counter slots
    localparam int NUM_CNT     = 10;
    localparam int CNT_IDENT   = 0;
    localparam int CNT_CONS    = 1;
    localparam int CNT_DIFF    = 2;
    localparam int CNT_COMP    = 3;
    localparam int CNT_UNK_A   = 4;
    localparam int CNT_UNK_B   = 5;
    localparam int CNT_GAP_A   = 6;
    localparam int CNT_GAP_B   = 7;
    localparam int CNT_LEN_A   = 8;
    localparam int CNT_LEN_B   = 9;

    typedef enum logic [2:0] {
        CLS_SKIP    = 3'd0,
        CLS_GAP_UNK = 3'd1,
        CLS_IDENT   = 3'd2,
        CLS_CONS    = 3'd3,
        CLS_DIFF    = 3'd4
    } t_pair_class;

    typedef struct packed {
        logic        skip;
        logic        gap_a;
        logic        gap_b;
        logic        unk_a;
        logic        unk_b;
        logic        compared;
        logic        ident;
        logic        cons;
        logic        diff;
        t_pair_class cls;
    } t_pair_flags;

    // one direction of the conservative substitution groups
    function automatic logic one_way(input logic [7:0] a, input logic [7:0] b);
        logic r;
        r = 1'b0;
        case (a)
            CH_A:    r = (b == CH_S);
            CH_D:    r = b inside {CH_E, CH_N};
            CH_E:    r = (b == CH_Q);
            CH_F:    r = (b == CH_Y);
            CH_I:    r = b inside {CH_L, CH_V};
            CH_K:    r = (b == CH_R);
            CH_L:    r = (b == CH_V);
            CH_N:    r = (b == CH_Q);
            CH_S:    r = (b == CH_T);
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_conservative(input logic [7:0] a, input logic [7:0] b);
        return one_way(a, b) || one_way(b, a);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/arps_classify.sv -----
// pair classifier: gap, unknown and substitution flags for one residue pair
// depends on arps_pkg
`default_nettype none

module arps_classify
    import arps_pkg::*;
(
    input  wire logic [7:0]  i_res_a,
    input  wire logic [7:0]  i_res_b,
    output t_pair_flags      o_flags
);

    logic w_gap_a, w_gap_b, w_unk_a, w_unk_b, w_skip, w_comp, w_same, w_cons;

    assign w_gap_a = (i_res_a == CH_GAP);
    assign w_gap_b = (i_res_b == CH_GAP);
    assign w_unk_a = (i_res_a == CH_UNK);
    assign w_unk_b = (i_res_b == CH_UNK);
    assign w_skip  = w_gap_a && w_gap_b;
    assign w_comp  = !(w_gap_a || w_gap_b || w_unk_a || w_unk_b);
    assign w_same  = (i_res_a == i_res_b);
    assign w_cons  = is_conservative(i_res_a, i_res_b);

    always_comb begin
        o_flags          = '0;
        o_flags.skip     = w_skip;
        o_flags.gap_a    = w_gap_a;
        o_flags.gap_b    = w_gap_b;
        o_flags.unk_a    = w_unk_a;
        o_flags.unk_b    = w_unk_b;
        o_flags.compared = w_comp;
        o_flags.ident    = w_comp && w_same;
        o_flags.cons     = w_comp && !w_same && w_cons;
        o_flags.diff     = w_comp && !w_same && !w_cons;
        if (w_skip) begin
            o_flags.cls = CLS_SKIP;
        end else if (!w_comp) begin
            o_flags.cls = CLS_GAP_UNK;
        end else if (w_same) begin
            o_flags.cls = CLS_IDENT;
        end else if (w_cons) begin
            o_flags.cls = CLS_CONS;
        end else begin
            o_flags.cls = CLS_DIFF;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/arps_counter.sv -----
// saturating event counter with synchronous clear on load
// no dependencies
`default_nettype none

module arps_counter #(
    parameter int WIDTH = 24
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire logic             i_clr,
    input  wire logic             i_inc,
    output logic [WIDTH-1:0]      o_count
);

    logic [WIDTH-1:0] r_count, n_count, w_base;

    assign w_base = i_clr ? '0 : r_count;

    always_comb begin
        n_count = r_count;
        if (i_load) begin
            n_count = (i_inc && !(&w_base)) ? w_base + 1'b1 : w_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_count = r_count;

endmodule

`default_nettype wire

// ----- hdl/aligned_residue_pair_statistics.sv -----
// aligned residue pair statistics, top level: input register, classifier,
// counter bank and result register; depends on arps_pkg, arps_classify,
// arps_counter and aligned_residue_pair_statistics_macros.svh
//
// usage
//   input channel: one aligned residue pair per transaction, with start_new
//   to clear every counter before that pair counts. a transaction completes
//   when i_in_valid is high and o_in_stall is low
//   output channel: one result per input transaction, the pair class and all
//   ten counters after the update; taken when o_out_valid is high and
//   i_out_stall is low
//   path: a taken pair waits in the input register until the result slot
//   is free, then is classified into the counter bank and class register
//   throughput: one pair per cycle while i_out_stall is low, set by the single
//   classify and increment step from the input register to the counter registers
//   stall: a stalled result holds; one more pair waits in the input register,
//   after which o_in_stall rises until the result is taken
//   reset: synchronous, active low; empties both stages and zeroes counters
//   counters saturate at all ones
`default_nettype none

module aligned_residue_pair_statistics
    import arps_pkg::*;
#(
    parameter int COUNT_WIDTH = 24
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // input channel
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [7:0]             i_residue_first,
    input  wire logic [7:0]             i_residue_second,
    input  wire logic                   i_start_new,
    // output channel
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [2:0]                  o_pair_class,
    output logic [COUNT_WIDTH-1:0]      o_identical_count,
    output logic [COUNT_WIDTH-1:0]      o_conservative_count,
    output logic [COUNT_WIDTH-1:0]      o_different_count,
    output logic [COUNT_WIDTH-1:0]      o_compared_count,
    output logic [COUNT_WIDTH-1:0]      o_unknown_first_count,
    output logic [COUNT_WIDTH-1:0]      o_unknown_second_count,
    output logic [COUNT_WIDTH-1:0]      o_gap_first_count,
    output logic [COUNT_WIDTH-1:0]      o_gap_second_count,
    output logic [COUNT_WIDTH-1:0]      o_length_first_count,
    output logic [COUNT_WIDTH-1:0]      o_length_second_count
);

`include "aligned_residue_pair_statistics_macros.svh"

    // input stage
    logic        r_s1_valid;
    logic [7:0]  r_s1_res_a;
    logic [7:0]  r_s1_res_b;
    logic        r_s1_start;

    // result stage: class register plus the counter bank itself
    logic        r_out_valid;
    t_pair_class r_out_class;

    logic        w_load;      // input stage moves into the result stage
    logic        w_s1_take;   // new input transaction completes
    t_pair_flags w_flags;
    logic [NUM_CNT-1:0] w_inc;
    logic [COUNT_WIDTH-1:0] w_count [NUM_CNT];

    // result slot frees up when empty or being taken this cycle
    assign w_load     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !w_load;
    assign w_s1_take  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_take) begin
            r_s1_valid <= 1'b1;
        end else if (w_load) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_take) begin
            r_s1_res_a <= i_residue_first;
            r_s1_res_b <= i_residue_second;
            r_s1_start <= i_start_new;
        end
    end

    arps_classify u_classify (
        .i_res_a (r_s1_res_a),
        .i_res_b (r_s1_res_b),
        .o_flags (w_flags)
    );

    // which counters move for this pair; unknown implies not a gap
    always_comb begin
        w_inc            = '0;
        w_inc[CNT_IDENT] = w_flags.ident;
        w_inc[CNT_CONS]  = w_flags.cons;
        w_inc[CNT_DIFF]  = w_flags.diff;
        w_inc[CNT_COMP]  = w_flags.compared;
        w_inc[CNT_UNK_A] = w_flags.unk_a;
        w_inc[CNT_UNK_B] = w_flags.unk_b;
        w_inc[CNT_GAP_A] = !w_flags.skip && w_flags.gap_a;
        w_inc[CNT_GAP_B] = !w_flags.skip && w_flags.gap_b;
        w_inc[CNT_LEN_A] = !w_flags.gap_a;
        w_inc[CNT_LEN_B] = !w_flags.gap_b;
    end

    for (genvar g = 0; g < NUM_CNT; g++) begin : g_cnt
        arps_counter #(
            .WIDTH (COUNT_WIDTH)
        ) u_counter (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (w_load),
            .i_clr   (r_s1_start),
            .i_inc   (w_inc[g]),
            .o_count (w_count[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_class <= w_flags.cls;
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_pair_class           = r_out_class;
    assign o_identical_count      = w_count[CNT_IDENT];
    assign o_conservative_count   = w_count[CNT_CONS];
    assign o_different_count      = w_count[CNT_DIFF];
    assign o_compared_count       = w_count[CNT_COMP];
    assign o_unknown_first_count  = w_count[CNT_UNK_A];
    assign o_unknown_second_count = w_count[CNT_UNK_B];
    assign o_gap_first_count      = w_count[CNT_GAP_A];
    assign o_gap_second_count     = w_count[CNT_GAP_B];
    assign o_length_first_count   = w_count[CNT_LEN_A];
    assign o_length_second_count  = w_count[CNT_LEN_B];

    // input side only backs up when a pair is already waiting
    `ARPS_ASSERT_SAME(a_stall_needs_pair, i_clk, i_rst_n, o_in_stall, r_s1_valid, "stall with empty input stage")

    // a skipped pair without clear leaves the length counters alone
    `ARPS_ASSERT_NEXT(a_skip_holds, i_clk, i_rst_n, w_load && w_flags.skip && !r_s1_start, (o_length_first_count == $past(o_length_first_count)) && (o_length_second_count == $past(o_length_second_count)), "skipped pair moved a length counter")

    // after a clear at most one pair has been compared
    `ARPS_ASSERT_NEXT(a_clear_compared, i_clk, i_rst_n, w_load && r_s1_start, o_compared_count <= COUNT_WIDTH'(1), "compared count not cleared")

    // a non-skipped pair always leaves a length or gap count on the first side
    `ARPS_ASSERT_NEXT(a_first_side_counts, i_clk, i_rst_n, w_load && !w_flags.skip, (o_length_first_count != '0) || (o_gap_first_count != '0), "first side not counted")

endmodule

`default_nettype wire

// ----- sim/tb_aligned_residue_pair_statistics.sv -----
// self-checking testbench for aligned_residue_pair_statistics: a directed
// stimulus table, then random alignments, checked against a local predictor
// depends on arps_pkg and the aligned_residue_pair_statistics rtl

module tb_aligned_residue_pair_statistics;
    import arps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // counters at their full width
    localparam int CNT_W       = 24;
    localparam int RANDOM_PAIRS = 1250;
    localparam int HOLD_CYCLES  = 40;

    typedef logic [CNT_W-1:0] t_tally;

    // one expected result: pair class and all ten counters after the pair
    typedef struct {
        t_pair_class cls;
        t_tally      cnt [NUM_CNT];
    } t_pair_stats;

    // one row of the directed table; typed rows carry their class and
    // compared count, the others rely on the predictor alone
    typedef struct {
        logic [7:0]  first;
        logic [7:0]  second;
        logic        clear;
        logic        typed;
        t_pair_class cls;
        int          compared;
    } t_script_row;

    localparam int SCRIPT_LEN = 26;

    logic                clk_r;
    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [7:0]          i_residue_first;
    logic [7:0]          i_residue_second;
    logic                i_start_new;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [2:0]          o_pair_class;
    t_tally              o_identical_count;
    t_tally              o_conservative_count;
    t_tally              o_different_count;
    t_tally              o_compared_count;
    t_tally              o_unknown_first_count;
    t_tally              o_unknown_second_count;
    t_tally              o_gap_first_count;
    t_tally              o_gap_second_count;
    t_tally              o_length_first_count;
    t_tally              o_length_second_count;

    // predictor state and the store of results still to come
    t_tally      running_tally [NUM_CNT];
    t_pair_stats pending_stats [$];
    int          mismatches;

    // shared control between the sending and the receiving process
    bit idle_on;      // random idling allowed in this stretch
    bit quiet;        // last part of the run: no idling on either side
    int hold_off;     // cycles the receiver still has to hold off

    // counter names in slot order, for mismatch reports
    string cnt_name [NUM_CNT] = '{
        "identical_count", "conservative_count", "different_count",
        "compared_count", "unknown_first_count", "unknown_second_count",
        "gap_first_count", "gap_second_count", "length_first_count",
        "length_second_count"
    };

    // residue alphabet and the conservative groups as letter pairs
    string amino_letters = "ACDEFGHIKLMNPQRSTVWY";
    string similar_pairs = "ASDEDNEQNQFYILIVLVKRST";

    // directed table: clears, every class, gaps and unknowns on each side,
    // lower case, byte extremes, clear on a skipped pair, every group
    t_script_row script [SCRIPT_LEN] = '{
        '{CH_GAP, CH_GAP, 1'b1, 1'b1, CLS_SKIP,    0},
        '{CH_A,   CH_A,   1'b1, 1'b1, CLS_IDENT,   1},
        '{CH_A,   CH_S,   1'b0, 1'b1, CLS_CONS,    2},
        '{CH_S,   CH_A,   1'b0, 1'b1, CLS_CONS,    3},
        '{CH_A,   CH_V,   1'b0, 1'b1, CLS_DIFF,    4},
        '{CH_GAP, CH_A,   1'b0, 1'b1, CLS_GAP_UNK, 4},
        '{CH_A,   CH_GAP, 1'b0, 1'b1, CLS_GAP_UNK, 4},
        '{CH_UNK, CH_A,   1'b0, 1'b1, CLS_GAP_UNK, 4},
        '{CH_A,   CH_UNK, 1'b0, 1'b1, CLS_GAP_UNK, 4},
        '{CH_UNK, CH_UNK, 1'b0, 1'b1, CLS_GAP_UNK, 4},
        '{CH_UNK, CH_GAP, 1'b0, 1'b1, CLS_GAP_UNK, 4},
        '{"a",    "s",    1'b0, 1'b0, CLS_SKIP,    0},
        '{"x",    "x",    1'b0, 1'b0, CLS_SKIP,    0},
        '{8'h00,  8'hFF,  1'b0, 1'b0, CLS_SKIP,    0},
        '{8'hFF,  8'hFF,  1'b0, 1'b0, CLS_SKIP,    0},
        '{CH_GAP, CH_GAP, 1'b1, 1'b1, CLS_SKIP,    0},
        '{CH_E,   CH_D,   1'b0, 1'b1, CLS_CONS,    1},
        '{CH_D,   CH_N,   1'b0, 1'b1, CLS_CONS,    2},
        '{CH_Q,   CH_E,   1'b0, 1'b1, CLS_CONS,    3},
        '{CH_N,   CH_Q,   1'b0, 1'b1, CLS_CONS,    4},
        '{CH_Y,   CH_F,   1'b0, 1'b1, CLS_CONS,    5},
        '{CH_I,   CH_L,   1'b0, 1'b1, CLS_CONS,    6},
        '{CH_V,   CH_I,   1'b0, 1'b1, CLS_CONS,    7},
        '{CH_L,   CH_V,   1'b0, 1'b1, CLS_CONS,    8},
        '{CH_R,   CH_K,   1'b0, 1'b1, CLS_CONS,    9},
        '{CH_T,   CH_S,   1'b0, 1'b1, CLS_CONS,    10}
    };

    aligned_residue_pair_statistics #(
        .COUNT_WIDTH(CNT_W)
    ) dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_in_valid             (i_in_valid),
        .o_in_stall             (o_in_stall),
        .i_residue_first        (i_residue_first),
        .i_residue_second       (i_residue_second),
        .i_start_new            (i_start_new),
        .o_out_valid            (o_out_valid),
        .i_out_stall            (i_out_stall),
        .o_pair_class           (o_pair_class),
        .o_identical_count      (o_identical_count),
        .o_conservative_count   (o_conservative_count),
        .o_different_count      (o_different_count),
        .o_compared_count       (o_compared_count),
        .o_unknown_first_count  (o_unknown_first_count),
        .o_unknown_second_count (o_unknown_second_count),
        .o_gap_first_count      (o_gap_first_count),
        .o_gap_second_count     (o_gap_second_count),
        .o_length_first_count   (o_length_first_count),
        .o_length_second_count  (o_length_second_count)
    );

    assign i_clk = clk_r;

    // 4 ns clock
    initial begin
        clk_r = 1'b0;
        forever #2 clk_r = ~clk_r;
    end

    // saturating increment of one counter slot
    function automatic void bump_tally(input int slot);
        if (running_tally[slot] != '1)
            running_tally[slot] = running_tally[slot] + 1'b1;
    endfunction

    // unordered membership in the conservative groups; the pair is sorted
    // so each group needs one case item
    function automatic bit similar_residues(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        bit         hit;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        case ({lo, hi})
            {CH_A, CH_S}, {CH_D, CH_E}, {CH_D, CH_N}, {CH_E, CH_Q},
            {CH_N, CH_Q}, {CH_F, CH_Y}, {CH_I, CH_L}, {CH_I, CH_V},
            {CH_L, CH_V}, {CH_K, CH_R}, {CH_S, CH_T}: hit = 1'b1;
            default:                                  hit = 1'b0;
        endcase
        return hit;
    endfunction

    // advance the running tally by one pair and return the expected result
    function automatic t_pair_stats tally_pair(input logic [7:0] a, input logic [7:0] b,
                                               input logic clear);
        t_pair_stats r;
        bit          gap_a;
        bit          gap_b;
        bit          unk_a;
        bit          unk_b;
        gap_a = (a == CH_GAP);
        gap_b = (b == CH_GAP);
        unk_a = (a == CH_UNK);
        unk_b = (b == CH_UNK);
        if (clear)
            foreach (running_tally[k]) running_tally[k] = '0;
        if (gap_a && gap_b) begin
            // both gaps: skipped, counters untouched
            r.cls = CLS_SKIP;
        end else begin
            bump_tally(gap_a ? CNT_GAP_A : CNT_LEN_A);
            bump_tally(gap_b ? CNT_GAP_B : CNT_LEN_B);
            if (unk_a) bump_tally(CNT_UNK_A);
            if (unk_b) bump_tally(CNT_UNK_B);
            if (gap_a || gap_b || unk_a || unk_b) begin
                r.cls = CLS_GAP_UNK;
            end else begin
                bump_tally(CNT_COMP);
                if (a == b) begin
                    bump_tally(CNT_IDENT);
                    r.cls = CLS_IDENT;
                end else if (similar_residues(a, b)) begin
                    bump_tally(CNT_CONS);
                    r.cls = CLS_CONS;
                end else begin
                    bump_tally(CNT_DIFF);
                    r.cls = CLS_DIFF;
                end
            end
        end
        r.cnt = running_tally;
        return r;
    endfunction

    // offer one pair, hold it until taken, then log its expected result;
    // typed rows override class and compared count with their own values
    task automatic send_pair(input logic [7:0] a, input logic [7:0] b, input logic clear,
                             input logic typed, input t_pair_class cls, input int compared);
        t_pair_stats want;
        if (idle_on && !quiet && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_residue_first  <= a;
        i_residue_second <= b;
        i_start_new      <= clear;
        do @(posedge i_clk); while (o_in_stall);
        want = tally_pair(a, b, clear);
        if (typed) begin
            want.cls           = cls;
            want.cnt[CNT_COMP] = t_tally'(compared);
        end
        pending_stats.push_back(want);
    endtask

    // one random pair of an alignment; identity-heavy alignments drive the
    // identical and compared counters up quickly
    task automatic pick_pair(input bit ident_heavy, output logic [7:0] a,
                             output logic [7:0] b);
        int r;
        int k;
        r = $urandom_range(0, 99);
        a = amino_letters.getc($urandom_range(0, 19));
        b = amino_letters.getc($urandom_range(0, 19));
        if (ident_heavy) begin
            if (r < 90) b = a;
        end else if (r < 8) begin
            a = CH_GAP;
        end else if (r < 16) begin
            b = CH_GAP;
        end else if (r < 19) begin
            if (r == 18) b = CH_UNK; else a = CH_UNK;
            if (r == 16) b = CH_UNK;
        end else if (r < 25) begin
            // raw bytes, lower case and control codes included
            a = 8'($urandom_range(0, 255));
            b = 8'($urandom_range(0, 255));
        end else if (r < 28) begin
            a = CH_GAP;
            b = CH_GAP;
        end else if (r < 48) begin
            k = 2 * $urandom_range(0, 10);
            a = similar_pairs.getc(k);
            b = similar_pairs.getc(k + 1);
            if ($urandom_range(0, 1) == 1) begin
                a = similar_pairs.getc(k + 1);
                b = similar_pairs.getc(k);
            end
        end else if (r < 72) begin
            b = a;
        end
    endtask

    // one alignment: cleared at its first pair, rarely cleared mid-way
    task automatic send_alignment(input int len, input bit ident_heavy);
        logic [7:0] a;
        logic [7:0] b;
        logic       clear;
        for (int i = 0; i < len; i++) begin
            pick_pair(ident_heavy, a, b);
            clear = (i == 0) || ($urandom_range(0, 199) == 0);
            send_pair(a, b, clear, 1'b0, CLS_SKIP, 0);
        end
    endtask

    // wait until every logged result has come back
    task automatic drain_results();
        while (pending_stats.size() != 0) @(posedge i_clk);
    endtask

    // stimulus side: reset, directed table, random alignments, wrap-up
    initial begin : pair_source
        int  sent;
        int  len;
        bit  pressured;
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_residue_first  = '0;
        i_residue_second = '0;
        i_start_new      = 1'b0;
        idle_on          = 1'b1;
        quiet            = 1'b0;
        hold_off         = 0;
        mismatches       = 0;
        sent             = 0;
        pressured        = 1'b0;
        foreach (running_tally[k]) running_tally[k] = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        for (int i = 0; i < SCRIPT_LEN; i++)
            send_pair(script[i].first, script[i].second, script[i].clear,
                      script[i].typed, script[i].cls, script[i].compared);

        // one long identity-heavy alignment first
        send_alignment(300, 1'b1);
        sent = 300;

        while (sent < RANDOM_PAIRS) begin
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(260, 320);
            else
                len = $urandom_range(3, 60);
            // about half the alignments run without sender idling
            idle_on = ($urandom_range(0, 1) == 1);

            if (!pressured && sent > 500) begin
                // receiver holds off while pairs keep coming, so the block
                // fills and stalls its input; then pause until drained
                pressured = 1'b1;
                idle_on   = 1'b0;
                hold_off  = HOLD_CYCLES;
                send_alignment(16, 1'b0);
                sent += 16;
                i_in_valid <= 1'b0;
                drain_results();
                idle_on = 1'b1;
            end

            // idling stops at a fixed point, and the run ends on its count
            if (sent >= RANDOM_PAIRS - 200)
                quiet = 1'b1;
            else if (sent + len > RANDOM_PAIRS - 200)
                len = RANDOM_PAIRS - 200 - sent;
            if (sent + len > RANDOM_PAIRS)
                len = RANDOM_PAIRS - sent;
            send_alignment(len, $urandom_range(0, 7) == 0);
            sent += len;
        end

        i_in_valid <= 1'b0;
        drain_results();
        // give the block time to return any stray results
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending_stats.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // result side: random stall bursts, the long hold-off, and checking of
    // every transaction against the oldest expectation
    initial begin : stats_sink
        int          stall_left;
        int          calm_left;
        t_pair_stats want;
        t_tally      seen [NUM_CNT];
        stall_left  = 0;
        calm_left   = 0;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                seen[CNT_IDENT] = o_identical_count;
                seen[CNT_CONS]  = o_conservative_count;
                seen[CNT_DIFF]  = o_different_count;
                seen[CNT_COMP]  = o_compared_count;
                seen[CNT_UNK_A] = o_unknown_first_count;
                seen[CNT_UNK_B] = o_unknown_second_count;
                seen[CNT_GAP_A] = o_gap_first_count;
                seen[CNT_GAP_B] = o_gap_second_count;
                seen[CNT_LEN_A] = o_length_first_count;
                seen[CNT_LEN_B] = o_length_second_count;
                if (pending_stats.size() == 0) begin
                    $error("result transaction with no pair outstanding");
                    mismatches++;
                end else begin
                    want = pending_stats.pop_front();
                    if (o_pair_class !== want.cls) begin
                        $error("pair_class expected %0d got %0d", want.cls, o_pair_class);
                        mismatches++;
                    end
                    foreach (seen[k])
                        if (seen[k] !== want.cnt[k]) begin
                            $error("%s expected %0d got %0d", cnt_name[k], want.cnt[k],
                                   seen[k]);
                            mismatches++;
                        end
                end
            end

            // next cycle's stall
            if (hold_off > 0) begin
                hold_off--;
                i_out_stall <= 1'b1;
            end else if (quiet) begin
                i_out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (calm_left > 0) begin
                calm_left--;
                i_out_stall <= 1'b0;
            end else if ($urandom_range(0, 1) == 1) begin
                stall_left = $urandom_range(1, 13) - 1;
                i_out_stall <= 1'b1;
            end else begin
                calm_left = $urandom_range(1, 40) - 1;
                i_out_stall <= 1'b0;
            end
        end
    end

    // watchdog, far beyond the slowest correct run
    initial begin : watchdog
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/arps_pkg.sv
hdl/arps_classify.sv
hdl/arps_counter.sv
hdl/aligned_residue_pair_statistics.sv
sim/tb_aligned_residue_pair_statistics.sv
